// File: sv/lattice_basis_gauss_reduce_top_defines.svh
// Assertion macros used by the checker file.
`ifndef LATTICE_BASIS_GAUSS_REDUCE_TOP_DEFINES_SVH
`define LATTICE_BASIS_GAUSS_REDUCE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LBGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbgr check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define LBGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbgr check failed");

`endif

// File: sv/lbgr_pkg.sv
package lbgr_pkg;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} operand_t;

	typedef struct packed {
		logic signed [31:0] long_x;
		logic signed [31:0] long_y;
		logic signed [31:0] long_z;
		logic signed [31:0] short_x;
		logic signed [31:0] short_y;
		logic signed [31:0] short_z;
		logic               collapsed;
		logic               hit_limit;
	} result_t;

	localparam logic [64:0] P_LIMIT = 65'h2_0000_0000;
	localparam logic [63:0] R_LIMIT = 64'h1_0000_0000;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? 32'(-x) : 32'(x);
		return r;
	endfunction

endpackage

// File: sv/lbgr_mul.sv
module lbgr_mul
	import lbgr_pkg::*;
(
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [31:0] b,
	output logic [64:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= 65'(a) * 65'(b);
	end

endmodule

// File: sv/lbgr_div.sv
module lbgr_div
	import lbgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic        active_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [64:0] sh;
	logic        ge;
	logic        rnd_up;

	assign sh     = {rem_q, quo_q[63]};
	assign ge     = sh >= {1'b0, den_q};
	assign rnd_up = rem_q >= (den_q - rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
				rem_q    <= '0;
				quo_q    <= num;
				den_q    <= den;
			end else if (active_q) begin
				if (cnt_q == 7'd64) begin
					quo_q    <= quo_q + 64'(rnd_up);
					done_q   <= 1'b1;
					active_q <= 1'b0;
				end else begin
					rem_q <= ge ? 64'(sh - {1'b0, den_q}) : sh[63:0];
					quo_q <= {quo_q[62:0], ge};
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: sv/lattice_basis_gauss_reduce_top.sv
// Each accepted start runs R rounds (1 to MAX_ROUNDS); the 64-step restoring divider
// takes most of each round in which it runs.
// Throughput: one word at a time; busy stays high until the result cycle.
// The result shows for one cycle with done; the receiver cannot stall it.
// Reset (arst_n low) returns the block to idle and clears min_length to zero.
module lattice_basis_gauss_reduce_top
	import lbgr_pkg::*;
#(
	parameter int MAX_ROUNDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  operand_t    operand,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MSQ  = 11'b00000000010,
		S_NRMU = 11'b00000000100,
		S_NRMV = 11'b00000001000,
		S_DOTP = 11'b00000010000,
		S_DIVS = 11'b00000100000,
		S_SCAL = 11'b00001000000,
		S_NRMW = 11'b00010000000,
		S_DECI = 11'b00100000000,
		S_SPR1 = 11'b01000000000,
		S_SPR2 = 11'b10000000000
	} state_t;

	state_t              state_q;
	logic [1:0]          cnt_q;
	logic [RW-1:0]       rnd_q;
	logic [30:0]         min_q;
	logic [61:0]         minsq_q;
	logic signed [31:0]  u_q [3];
	logic signed [31:0]  v_q [3];
	logic signed [31:0]  w_q [3];
	logic [63:0]         nu_q;
	logic [63:0]         nv_q;
	logic [63:0]         nw_q;
	logic                neg_q;
	logic [32:0]         q_q;
	logic signed [65:0]  acc_q;
	logic                sgn_s1;
	result_t             res_q;
	logic                done_q;

	logic [1:0]          sel;
	logic [1:0]          prv;
	logic [32:0]         mul_a;
	logic [31:0]         mul_b;
	logic                mul_sa;
	logic [64:0]         p_s1;
	logic signed [65:0]  acc_nxt;
	logic [63:0]         acc_mag;
	logic [33:0]         pm;
	logic signed [34:0]  ux;
	logic signed [34:0]  diff;
	logic signed [31:0]  wsat;
	logic                div_start;
	logic                div_done;
	logic [63:0]         div_quo;

	assign sel = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
	assign prv = cnt_q - 2'd1;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sa = 1'b0;
		unique case (state_q)
			S_MSQ: begin
				mul_a = {2'b00, min_q};
				mul_b = {1'b0, min_q};
			end
			S_NRMU: begin
				mul_a = {1'b0, mag32(u_q[sel])};
				mul_b = mag32(u_q[sel]);
			end
			S_NRMV: begin
				mul_a = {1'b0, mag32(v_q[sel])};
				mul_b = mag32(v_q[sel]);
			end
			S_DOTP: begin
				mul_a  = {1'b0, mag32(u_q[sel])};
				mul_b  = mag32(v_q[sel]);
				mul_sa = u_q[sel][31] ^ v_q[sel][31];
			end
			S_SCAL: begin
				mul_a  = q_q;
				mul_b  = mag32(v_q[sel]);
				mul_sa = neg_q ^ v_q[sel][31];
			end
			S_NRMW: begin
				mul_a = {1'b0, mag32(w_q[sel])};
				mul_b = mag32(w_q[sel]);
			end
			default: begin
			end
		endcase
	end

	lbgr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (p_s1)
	);

	assign acc_nxt = sgn_s1 ? (acc_q - $signed({1'b0, p_s1}))
	                        : (acc_q + $signed({1'b0, p_s1}));
	assign acc_mag = acc_nxt[65] ? 64'(-acc_nxt) : acc_nxt[63:0];

	assign pm   = (p_s1 > P_LIMIT) ? P_LIMIT[33:0] : p_s1[33:0];
	assign ux   = 35'(u_q[prv]);
	assign diff = sgn_s1 ? (ux + $signed({1'b0, pm})) : (ux - $signed({1'b0, pm}));
	always_comb begin
		if (diff[34:31] == 4'b0000 || diff[34:31] == 4'b1111) begin
			wsat = diff[31:0];
		end else if (diff[34]) begin
			wsat = 32'sh8000_0000;
		end else begin
			wsat = 32'sh7FFF_FFFF;
		end
	end

	assign div_start = (state_q == S_DOTP) && (cnt_q == 2'd3) && (nv_q != 64'd0);

	lbgr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_mag),
		.den    (nv_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rnd_q   <= '0;
			min_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			sgn_s1 <= mul_sa;
			if (cfg_we) begin
				min_q <= cfg_wdata;
			end
			if (state_q == S_NRMU || state_q == S_NRMV || state_q == S_DOTP
					|| state_q == S_NRMW) begin
				acc_q <= (cnt_q == 2'd0) ? '0 : acc_nxt;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						u_q[0]  <= operand.first_x;
						u_q[1]  <= operand.first_y;
						u_q[2]  <= operand.first_z;
						v_q[0]  <= operand.second_x;
						v_q[1]  <= operand.second_y;
						v_q[2]  <= operand.second_z;
						rnd_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_MSQ;
					end
				end
				S_MSQ: begin
					if (cnt_q == 2'd1) begin
						minsq_q <= p_s1[61:0];
						cnt_q   <= '0;
						state_q <= S_NRMU;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				S_NRMU: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						nu_q    <= acc_mag;
						state_q <= S_NRMV;
					end
				end
				S_NRMV: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (acc_mag > nu_q) begin
							u_q  <= v_q;
							v_q  <= u_q;
							nu_q <= acc_mag;
							nv_q <= nu_q;
						end else begin
							nv_q <= acc_mag;
						end
						state_q <= S_DOTP;
					end
				end
				S_DOTP: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						neg_q <= acc_nxt[65];
						if (nv_q == 64'd0) begin
							q_q     <= '0;
							state_q <= S_SCAL;
						end else begin
							state_q <= S_DIVS;
						end
					end
				end
				S_DIVS: begin
					if (div_done) begin
						q_q     <= (div_quo > R_LIMIT) ? R_LIMIT[32:0] : div_quo[32:0];
						state_q <= S_SCAL;
					end
				end
				S_SCAL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q != 2'd0) begin
						w_q[prv] <= wsat;
					end
					if (cnt_q == 2'd3) begin
						state_q <= S_NRMW;
					end
				end
				S_NRMW: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						nw_q    <= acc_mag;
						state_q <= S_DECI;
					end
				end
				S_DECI: begin
					res_q.collapsed <= 1'b0;
					res_q.hit_limit <= 1'b0;
					res_q.short_x   <= v_q[0];
					res_q.short_y   <= v_q[1];
					res_q.short_z   <= v_q[2];
					res_q.long_x    <= w_q[0];
					res_q.long_y    <= w_q[1];
					res_q.long_z    <= w_q[2];
					done_q          <= 1'b1;
					state_q         <= S_IDLE;
					if (nw_q < {2'b00, minsq_q}) begin
						res_q.long_x    <= '0;
						res_q.long_y    <= '0;
						res_q.long_z    <= '0;
						res_q.collapsed <= 1'b1;
					end else if (nw_q < nv_q) begin
						if (rnd_q == RW'(MAX_ROUNDS - 1)) begin
							res_q.long_x    <= v_q[0];
							res_q.long_y    <= v_q[1];
							res_q.long_z    <= v_q[2];
							res_q.short_x   <= w_q[0];
							res_q.short_y   <= w_q[1];
							res_q.short_z   <= w_q[2];
							res_q.hit_limit <= 1'b1;
						end else begin
							u_q     <= v_q;
							v_q     <= w_q;
							nu_q    <= nv_q;
							nv_q    <= nw_q;
							rnd_q   <= rnd_q + RW'(1);
							cnt_q   <= '0;
							done_q  <= 1'b0;
							state_q <= S_DOTP;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// File: sv/lbgr_chk.sv
`include "lattice_basis_gauss_reduce_top_defines.svh"

module lbgr_chk
	import lbgr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`LBGR_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`LBGR_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`LBGR_ASSERT_IMP(a_flags_excl, clk, arst_n, done, !(result.collapsed && result.hit_limit))
	`LBGR_ASSERT_IMP(a_collapse_zero, clk, arst_n, done && result.collapsed, result.long_x == 32'sd0 && result.long_y == 32'sd0 && result.long_z == 32'sd0)
	`LBGR_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)

endmodule

bind lattice_basis_gauss_reduce_top lbgr_chk u_chk (.*);

// File: tb/tb_lattice_basis_gauss_reduce_top.sv
`timescale 1ns / 1ps

module tb_lattice_basis_gauss_reduce_top;
	import lbgr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	operand_t    operand;
	logic        busy;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [30:0] cfg_wdata;

	lattice_basis_gauss_reduce_top #(.MAX_ROUNDS(32)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operand(operand),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	localparam int ROUND_LIMIT = 32;
	localparam int STALL_LIMIT = 20000;

	typedef longint signed coord_t;
	typedef coord_t basis_vec_t [3];

	result_t     reduced_queue[$];
	logic [30:0] min_len;
	int          error_count;
	int          idle_cycles;
	bit          calm_sender;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] mag64(coord_t v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] exact_dot(basis_vec_t a, basis_vec_t b, output bit neg);
		logic [63:0] pos;
		logic [63:0] ngs;
		logic [63:0] p;
		pos = 0;
		ngs = 0;
		for (int i = 0; i < 3; i++) begin
			p = mag64(a[i]) * mag64(b[i]);
			if ((a[i] < 0) != (b[i] < 0)) begin
				ngs += p;
			end else begin
				pos += p;
			end
		end
		neg = pos < ngs;
		return neg ? ngs - pos : pos - ngs;
	endfunction

	function automatic logic [63:0] sq_len(basis_vec_t a);
		bit n;
		return exact_dot(a, a, n);
	endfunction

	function automatic coord_t clamp32(coord_t v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic result_t gauss_reduce(operand_t op);
		basis_vec_t u, v, w, t, la, sb;
		logic [63:0] minsq, d, n, q, rem, nw, m;
		bit neg, pneg, finished, collapse;
		coord_t p;
		result_t res;
		u[0] = op.first_x; u[1] = op.first_y; u[2] = op.first_z;
		v[0] = op.second_x; v[1] = op.second_y; v[2] = op.second_z;
		minsq = 64'(min_len) * 64'(min_len);
		finished = 0;
		collapse = 0;
		la = u;
		sb = v;
		for (int rnd = 0; rnd < ROUND_LIMIT && !finished; rnd++) begin
			if (sq_len(v) > sq_len(u)) begin
				t = u; u = v; v = t;
			end
			d = sq_len(v);
			n = exact_dot(u, v, neg);
			q = 0;
			if (d != 0) begin
				rem = n % d;
				q = n / d;
				if (rem >= d - rem) q++;
			end
			if (q > R_LIMIT) q = R_LIMIT;
			for (int i = 0; i < 3; i++) begin
				pneg = neg != (v[i] < 0);
				m = q * mag64(v[i]);
				if (m > 64'(P_LIMIT)) m = 64'(P_LIMIT);
				p = pneg ? -coord_t'(m) : coord_t'(m);
				w[i] = clamp32(u[i] - p);
			end
			nw = sq_len(w);
			if (nw < minsq) begin
				la = '{0, 0, 0}; sb = v; collapse = 1; finished = 1;
			end else if (nw < d) begin
				u = v; v = w;
			end else begin
				la = w; sb = v; finished = 1;
			end
		end
		if (!finished) begin
			la = u; sb = v;
		end
		res.long_x = la[0][31:0]; res.long_y = la[1][31:0]; res.long_z = la[2][31:0];
		res.short_x = sb[0][31:0]; res.short_y = sb[1][31:0]; res.short_z = sb[2][31:0];
		res.collapsed = collapse;
		res.hit_limit = !finished;
		return res;
	endfunction

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reduced_queue.size() == 0) begin
				$display("%0t: unexpected word expected none actual %h", $time, result);
				error_count++;
			end else begin
				result_t e;
				e = reduced_queue.pop_front();
				report_field("long_x", e.long_x, result.long_x);
				report_field("long_y", e.long_y, result.long_y);
				report_field("long_z", e.long_z, result.long_z);
				report_field("short_x", e.short_x, result.short_x);
				report_field("short_y", e.short_y, result.short_y);
				report_field("short_z", e.short_z, result.short_z);
				report_field("collapsed", 32'(e.collapsed), 32'(result.collapsed));
				report_field("hit_limit", 32'(e.hit_limit), 32'(result.hit_limit));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(operand_t op);
		if (!calm_sender) begin
			while ($urandom_range(99) < 38) @(posedge clk);
		end
		start <= 1'b1;
		operand <= op;
		do @(posedge clk); while (busy);
		reduced_queue.push_back(gauss_reduce(op));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		while (reduced_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_min_len(logic [30:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_len = val;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(16)) - 8) <<< 16;
			3: return 32'($signed($urandom_range(4000)) - 2000) <<< 8;
			4: return 32'($signed($urandom_range(200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic operand_t rand_operand();
		operand_t op;
		op = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		if ($urandom_range(9) == 0) begin
			op.second_x = op.first_x; op.second_y = op.first_y; op.second_z = op.first_z;
		end
		return op;
	endfunction

	task automatic test_directed;
		logic [31:0] mn;
		logic [31:0] mx;
		mn = 32'h8000_0000;
		mx = 32'h7FFF_FFFF;
		send_word('0);
		send_word({32'h10000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		send_word({32'd0, 32'd0, 32'd0, 32'h10000, 32'd0, 32'd0});
		send_word({32'h10000, 32'h10000, 32'd0, 32'h10000, 32'd0, 32'd0});
		send_word({32'h30000, 32'h10000, 32'd0, 32'h10000, 32'd0, 32'd0});
		send_word({32'h28000, 32'd0, 32'd0, 32'h10000, 32'd0, 32'd0});
		send_word({-32'sh28000, 32'd0, 32'd0, 32'h10000, 32'd0, 32'd0});
		send_word({mx, mx, mx, mx, mx, mx});
		send_word({mn, mn, mn, mn, mn, mn});
		send_word({mx, mn, mx, mn, mx, mn});
		send_word({mx, mx, mx, 32'd1, 32'd0, 32'd0});
		send_word({mn, mn, mn, 32'd1, 32'd1, 32'd1});
		send_word({mx, 32'd1, 32'd0, mx, 32'd0, 32'd1});
		send_word({32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h55555555, 32'hAAAAAAAA});
		send_word({32'd1000001, 32'd999999, 32'd3, 32'd1000000, 32'd1000000, 32'd3});
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			send_word(rand_operand());
		end
	endtask

	task automatic test_calm_stretch;
		calm_sender = 1;
		test_random(60);
		calm_sender = 0;
	endtask

	task automatic test_min_length;
		write_min_len(31'h10000);
		test_directed();
		test_random(50);
		write_min_len(31'h7FFF_FFFF);
		test_random(40);
		write_min_len(31'($urandom));
		test_random(40);
		write_min_len(31'h100);
		test_random(40);
		write_min_len('0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operand = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		min_len = '0;
		error_count = 0;
		idle_cycles = 0;
		calm_sender = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100);
		drain();
		test_calm_stretch();
		test_min_length();
		test_random(40);
		drain();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
